// ----- sv/voxel_grid_ray_traversal_unit_defines.svh -----
// Assertion macros for the voxel grid ray traversal unit.
`ifndef VOXEL_GRID_RAY_TRAVERSAL_UNIT_DEFINES_SVH
`define VOXEL_GRID_RAY_TRAVERSAL_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge out of reset.
`define VGRT_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("vgrt assertion failed");
// Condition that must hold in the cycle after the trigger.
`define VGRT_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("vgrt assertion failed");
`else
`define VGRT_ASSERT_ALWAYS(label, cond)
`define VGRT_ASSERT_NEXT(label, trig, cond)
`endif
`endif

// ----- sv/vgrt_pkg.sv -----
// Package with types and codes of the voxel grid ray traversal unit.
`timescale 1ns / 1ps
`default_nettype none
package vgrt_pkg;

  localparam int DW = 32;

  // Input commands.
  localparam logic [1:0] CMD_LOAD     = 2'd0;
  localparam logic [1:0] CMD_STEP     = 2'd1;
  localparam logic [1:0] CMD_STEP_HIT = 2'd2;
  localparam logic [1:0] CMD_QUERY    = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_SIZE_X  = 3'd0;
  localparam logic [2:0] REG_SIZE_Y  = 3'd1;
  localparam logic [2:0] REG_SIZE_Z  = 3'd2;
  localparam logic [2:0] REG_CELLS_X = 3'd3;
  localparam logic [2:0] REG_CELLS_Y = 3'd4;
  localparam logic [2:0] REG_CELLS_Z = 3'd5;

  // Per-axis step codes.
  localparam logic [1:0] ST_ZERO = 2'b00;
  localparam logic [1:0] ST_POS  = 2'b01;
  localparam logic [1:0] ST_NEG  = 2'b11;

  localparam logic signed [DW-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DW-1:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [4:0] {
    S_IDLE, S_LD_T, S_LD_SP, S_DIV, S_LD_CL, S_LD_LO, S_LD_BD, S_LD_B2,
    S_LD_DL, S_LD_NX, S_LD_EX, S_Q1, S_Q2, S_Q3, S_STEP,
    S_IX0, S_IX1, S_IX2, S_IX3, S_OUT
  } state_t;

  // Magnitude of a signed word; the most negative value maps to 2^31.
  function automatic logic [DW-1:0] mag32(input logic signed [DW-1:0] v);
    logic [DW:0] w;
    w = v[DW-1] ? ((DW+1)'(0) - {v[DW-1], v}) : {v[DW-1], v};
    return w[DW-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- sv/voxel_grid_ray_traversal_unit.sv -----
// Voxel grid ray traversal unit: 3D DDA walker with a shared multiplier and divider.
// A step or query passes through S_STEP to S_OUT; a step that moves the walk also passes S_IX0-S_IX3.
// A ray load runs per axis a bit-serial divider for the start voxel and three fixed-point
// products on the shared 32x32 multiplier, less where the start point is negative or the direction is zero.
// One item at a time; the next item is taken in the cycle after the result is taken.
// Reset (synchronous, active low) clears the walk state and loads default registers.
`timescale 1ns / 1ps
`default_nettype none
`include "voxel_grid_ray_traversal_unit_defines.svh"
module voxel_grid_ray_traversal_unit #(
  parameter int MAX_CELLS_PER_AXIS = 256,
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [30:0] cfg_wdata,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic signed [31:0] in_org_x,
  input  wire logic signed [31:0] in_org_y,
  input  wire logic signed [31:0] in_org_z,
  input  wire logic signed [31:0] in_dir_x,
  input  wire logic signed [31:0] in_dir_y,
  input  wire logic signed [31:0] in_dir_z,
  input  wire logic signed [31:0] in_inv_x,
  input  wire logic signed [31:0] in_inv_y,
  input  wire logic signed [31:0] in_inv_z,
  input  wire logic signed [31:0] in_t_start,
  input  wire logic signed [31:0] in_hit_dist,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [23:0] out_voxel_index,
  output      logic signed [31:0] out_t_exit,
  output      logic        out_done_res,
  output      logic        out_hit
);
  import vgrt_pkg::*;

  localparam int CW = (MAX_CELLS_PER_AXIS > 1) ? $clog2(MAX_CELLS_PER_AXIS) : 1;
  localparam int NW = $clog2(MAX_CELLS_PER_AXIS + 1);

  state_t state_r, state_nxt, ret_r;

  // Configuration registers.
  logic [30:0] vs_r [0:2];
  logic [8:0]  cells_r [0:2];
  logic [30:0] vs_eff [0:2];
  logic [NW-1:0] n_eff [0:2];

  // Latched item.
  logic [1:0] cmd_r;
  logic signed [31:0] org_r [0:2];
  logic signed [31:0] dir_r [0:2];
  logic signed [31:0] inv_r [0:2];
  logic signed [31:0] t_r, hitd_r;

  // Walk state.
  logic [CW-1:0] cell_r [0:2];
  logic [1:0] sgn_r [0:2];
  logic signed [31:0] nb_r [0:2];
  logic signed [31:0] delta_r [0:2];
  logic signed [31:0] exit_r;
  logic [23:0] cur_index_r;
  logic active_r, res_done_r, res_hit_r;
  logic [1:0] ax_r;

  // Shared multiplier and product accumulator.
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_r, acc_r, zterm_r;
  logic [42:0] qa_r;
  logic [31:0] qb_r;
  logic qneg_r;
  logic signed [31:0] qres_r;

  // Divider.
  logic [31:0] rem_r, quo_r;
  logic [4:0] cnt_r;

  // Effective register values.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      vs_eff[a] = (vs_r[a] == 31'd0) ? 31'd1 : vs_r[a];
      if (cells_r[a] == 9'd0) begin
        n_eff[a] = NW'(1);
      end else if (int'(cells_r[a]) > MAX_CELLS_PER_AXIS) begin
        n_eff[a] = NW'(MAX_CELLS_PER_AXIS);
      end else begin
        n_eff[a] = NW'(cells_r[a]);
      end
    end
  end

  // Final stage of a fixed-point product: shift, truncate and saturate.
  logic [74:0] qfull;
  logic qbig;
  logic [30:0] qmag;
  logic signed [31:0] qval;
  always_comb begin
    qfull = {prod_r[52:0], 22'b0} + {11'b0, acc_r};
    qbig  = (|qfull[74:31+FRAC_BITS]) || (qa_r[42] && (qb_r != 32'd0));
    qmag  = qfull[30+FRAC_BITS:FRAC_BITS];
    if (qbig) begin
      qval = qneg_r ? Q_MIN : Q_MAX;
    end else if (qneg_r) begin
      qval = -$signed({1'b0, qmag});
    end else begin
      qval = $signed({1'b0, qmag});
    end
  end

  // Start point and divider step.
  logic signed [32:0] sp;
  logic [31:0] dshift;
  logic dge;
  always_comb begin
    sp     = {org_r[ax_r][31], org_r[ax_r]} + {qres_r[31], qres_r};
    dshift = {rem_r[30:0], quo_r[31]};
    dge    = dshift >= {1'b0, vs_eff[ax_r]};
  end

  // Boundary operand for the current axis.
  logic [41:0] lo;
  logic signed [43:0] bnd;
  logic [43:0] bnd_mag;
  always_comb begin
    lo  = prod_r[41:0];
    bnd = $signed({2'b0, lo}) - 44'(org_r[ax_r]);
    if (sgn_r[ax_r] == ST_POS) begin
      bnd = bnd + $signed({13'b0, vs_eff[ax_r]});
    end
    bnd_mag = bnd[43] ? (44'd0 - bnd) : bnd;
  end

  // Step decision: axis choice, neighbour cell and boundary advance.
  logic [1:0] sel_ax;
  logic [CW:0] cell_up;
  logic off_grid, hit_ok, step_move;
  logic signed [32:0] nsum;
  logic signed [31:0] nb_adv;
  always_comb begin
    if (nb_r[0] < nb_r[1]) begin
      sel_ax = (nb_r[0] < nb_r[2]) ? 2'd0 : 2'd2;
    end else begin
      sel_ax = (nb_r[1] < nb_r[2]) ? 2'd1 : 2'd2;
    end
    cell_up = {1'b0, cell_r[sel_ax]} + (CW+1)'(1);
    // A shrunken grid can leave the cell beyond the new far edge.
    if (sgn_r[sel_ax] == ST_NEG) begin
      off_grid = (cell_r[sel_ax] == CW'(0)) ||
                 (12'(cell_r[sel_ax]) > 12'(n_eff[sel_ax]));
    end else begin
      off_grid = (12'(cell_up) >= 12'(n_eff[sel_ax]));
    end
    hit_ok = (cmd_r == CMD_STEP_HIT) && (hitd_r <= exit_r);
    step_move = (cmd_r != CMD_QUERY) && active_r && !hit_ok &&
                (sgn_r[sel_ax] != ST_ZERO) && !off_grid;
    nsum = {nb_r[sel_ax][31], nb_r[sel_ax]} + {delta_r[sel_ax][31], delta_r[sel_ax]};
    if (nsum[32] != nsum[31]) begin
      nb_adv = nsum[32] ? Q_MIN : Q_MAX;
    end else begin
      nb_adv = nsum[31:0];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = (in_cmd == CMD_LOAD) ? S_LD_T : S_STEP;
      S_LD_T:  state_nxt = S_Q1;
      S_Q1:    state_nxt = S_Q2;
      S_Q2:    state_nxt = S_Q3;
      S_Q3:    state_nxt = ret_r;
      S_LD_SP: state_nxt = sp[32] ? S_LD_LO : S_DIV;
      S_DIV:   if (cnt_r == 5'd31) state_nxt = S_LD_CL;
      S_LD_CL: state_nxt = S_LD_LO;
      S_LD_LO: state_nxt = S_LD_BD;
      S_LD_BD: state_nxt = (sgn_r[ax_r] == ST_ZERO) ? S_LD_NX : S_Q1;
      S_LD_B2: state_nxt = S_Q1;
      S_LD_DL: state_nxt = S_LD_NX;
      S_LD_NX: state_nxt = (ax_r == 2'd2) ? S_LD_EX : S_LD_T;
      S_LD_EX: state_nxt = S_IX0;
      S_STEP:  state_nxt = step_move ? S_IX0 : S_OUT;
      S_IX0:   state_nxt = S_IX1;
      S_IX1:   state_nxt = S_IX2;
      S_IX2:   state_nxt = S_IX3;
      S_IX3:   state_nxt = S_OUT;
      S_OUT:   if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Handshake and multiplier operand selection.
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    out_valid = (state_r == S_OUT);
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state_r)
      S_Q1: begin
        mul_a = {10'b0, qa_r[21:0]};
        mul_b = qb_r;
      end
      S_Q2: begin
        mul_a = {11'b0, qa_r[42:22]};
        mul_b = qb_r;
      end
      S_LD_LO: begin
        mul_a = 32'(cell_r[ax_r]);
        mul_b = {1'b0, vs_eff[ax_r]};
      end
      S_IX0: begin
        mul_a = 32'(n_eff[0]);
        mul_b = 32'(n_eff[1]);
      end
      S_IX1: begin
        mul_a = 32'(cell_r[2]);
        mul_b = prod_r[31:0];
      end
      S_IX2: begin
        mul_a = 32'(cell_r[1]);
        mul_b = 32'(n_eff[0]);
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign out_voxel_index = cur_index_r;
  assign out_t_exit      = exit_r;
  assign out_done_res    = res_done_r;
  assign out_hit         = res_hit_r;

  // Shared multiplier with registered product.
  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int a = 0; a < 3; a++) begin
        vs_r[a]    <= 31'd65536;
        cells_r[a] <= 9'd1;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SIZE_X:  vs_r[0] <= cfg_wdata;
          REG_SIZE_Y:  vs_r[1] <= cfg_wdata;
          REG_SIZE_Z:  vs_r[2] <= cfg_wdata;
          REG_CELLS_X: cells_r[0] <= cfg_wdata[8:0];
          REG_CELLS_Y: cells_r[1] <= cfg_wdata[8:0];
          REG_CELLS_Z: cells_r[2] <= cfg_wdata[8:0];
          default: ;
        endcase
      end
    end
  end

  // Item capture and scratch registers of the sequencer.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      cmd_r    <= in_cmd;
      org_r[0] <= in_org_x;
      org_r[1] <= in_org_y;
      org_r[2] <= in_org_z;
      dir_r[0] <= in_dir_x;
      dir_r[1] <= in_dir_y;
      dir_r[2] <= in_dir_z;
      inv_r[0] <= in_inv_x;
      inv_r[1] <= in_inv_y;
      inv_r[2] <= in_inv_z;
      t_r      <= in_t_start;
      hitd_r   <= in_hit_dist;
    end
    case (state_r)
      S_LD_T: begin
        qa_r   <= (t_r > 32'sd0) ? {11'b0, t_r[31:0]} : 43'd0;
        qb_r   <= mag32(dir_r[ax_r]);
        qneg_r <= dir_r[ax_r][31];
        ret_r  <= S_LD_SP;
      end
      S_Q2: acc_r <= prod_r;
      S_Q3: qres_r <= qval;
      S_LD_SP: begin
        rem_r <= 32'd0;
        quo_r <= sp[31:0];
        cnt_r <= 5'd0;
      end
      S_DIV: begin
        rem_r <= dge ? (dshift - {1'b0, vs_eff[ax_r]}) : dshift;
        quo_r <= {quo_r[30:0], dge};
        cnt_r <= cnt_r + 5'd1;
      end
      S_LD_BD: begin
        qa_r   <= bnd_mag[42:0];
        qb_r   <= mag32(inv_r[ax_r]);
        qneg_r <= bnd[43] ^ inv_r[ax_r][31];
        ret_r  <= S_LD_B2;
      end
      S_LD_B2: begin
        qa_r   <= {12'b0, vs_eff[ax_r]};
        qb_r   <= mag32(inv_r[ax_r]);
        qneg_r <= inv_r[ax_r][31];
        ret_r  <= S_LD_DL;
      end
      S_IX2: zterm_r <= prod_r;
      default: ;
    endcase
  end

  // Walk state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        cell_r[a]  <= CW'(0);
        sgn_r[a]   <= ST_ZERO;
        nb_r[a]    <= Q_MAX;
        delta_r[a] <= 32'sd0;
      end
      exit_r      <= Q_MAX;
      cur_index_r <= 24'd0;
      active_r    <= 1'b0;
      res_done_r  <= 1'b0;
      res_hit_r   <= 1'b0;
      ax_r        <= 2'd0;
    end else begin
      case (state_r)
        S_IDLE: ax_r <= 2'd0;
        S_LD_T: begin
          if (dir_r[ax_r] > 32'sd0) begin
            sgn_r[ax_r] <= ST_POS;
          end else if (dir_r[ax_r] < 32'sd0) begin
            sgn_r[ax_r] <= ST_NEG;
          end else begin
            sgn_r[ax_r] <= ST_ZERO;
          end
        end
        S_LD_SP: if (sp[32]) cell_r[ax_r] <= CW'(0);
        S_LD_CL: begin
          if (quo_r >= 32'(n_eff[ax_r])) begin
            cell_r[ax_r] <= CW'(n_eff[ax_r] - NW'(1));
          end else begin
            cell_r[ax_r] <= quo_r[CW-1:0];
          end
        end
        S_LD_BD: begin
          if (sgn_r[ax_r] == ST_ZERO) begin
            nb_r[ax_r]    <= Q_MAX;
            delta_r[ax_r] <= 32'sd0;
          end
        end
        S_LD_B2: nb_r[ax_r] <= qres_r;
        S_LD_DL: begin
          if (sgn_r[ax_r] == ST_POS) begin
            delta_r[ax_r] <= qres_r;
          end else begin
            delta_r[ax_r] <= (qres_r == Q_MIN) ? Q_MAX : -qres_r;
          end
        end
        S_LD_NX: ax_r <= ax_r + 2'd1;
        S_LD_EX: begin
          if (nb_r[1] < nb_r[0] && nb_r[1] <= nb_r[2]) begin
            exit_r <= nb_r[1];
          end else if (nb_r[2] < nb_r[0] && nb_r[2] < nb_r[1]) begin
            exit_r <= nb_r[2];
          end else begin
            exit_r <= nb_r[0];
          end
          active_r   <= 1'b1;
          res_done_r <= 1'b0;
          res_hit_r  <= 1'b0;
        end
        S_STEP: begin
          res_hit_r <= 1'b0;
          if (cmd_r == CMD_QUERY) begin
            res_done_r <= !active_r;
          end else if (!active_r) begin
            res_done_r <= 1'b1;
          end else if (hit_ok) begin
            active_r   <= 1'b0;
            res_done_r <= 1'b1;
            res_hit_r  <= 1'b1;
          end else if (!step_move) begin
            active_r   <= 1'b0;
            res_done_r <= 1'b1;
          end else begin
            res_done_r <= 1'b0;
            if (sgn_r[sel_ax] == ST_NEG) begin
              cell_r[sel_ax] <= cell_r[sel_ax] - CW'(1);
            end else begin
              cell_r[sel_ax] <= cell_up[CW-1:0];
            end
            nb_r[sel_ax] <= nb_adv;
            exit_r       <= nb_adv;
          end
        end
        S_IX3: cur_index_r <= 24'(64'(cell_r[0]) + prod_r + zterm_r);
        default: ;
      endcase
    end
  end

  // Checks on the sequencer and result flags.
  `VGRT_ASSERT_ALWAYS(a_no_overlap, !(in_ready && out_valid))
  `VGRT_ASSERT_NEXT(a_ready_after_out, out_valid && out_ready, in_ready)
  `VGRT_ASSERT_ALWAYS(a_hit_ends_walk, !(out_valid && out_hit) || out_done_res)
  `VGRT_ASSERT_NEXT(a_load_starts_walk, in_valid && in_ready && in_cmd == CMD_LOAD, !out_valid)

endmodule
`default_nettype wire
